// File: hw/rtl/rsu_pkg.sv
// ----------------------------------------------------------------------------
// rsu_pkg
// Shared types and constants of the rank-sum U statistic block.
// ----------------------------------------------------------------------------
`default_nettype none

package rsu_pkg;

	localparam int VAL_W  = 16;
	localparam int U_W    = 20;
	localparam int RHO_W  = 17;
	localparam int Q_BITS = 17;
	localparam int QCNT_W = 5;

	typedef struct packed {
		logic [VAL_W-1:0] sample_value;
		logic             in_variant_group;
		logic             last_sample;
	} in_word_t;

	typedef struct packed {
		logic [U_W-1:0]   u_var_twice;
		logic [U_W-1:0]   u_ref_twice;
		logic [RHO_W-1:0] rho_fraction;
		logic             empty_group;
		logic             dropped_samples;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PREP,
		ST_SCAN,
		ST_DRAIN,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

// File: hw/rtl/rsu_ram.sv
// ----------------------------------------------------------------------------
// rsu_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rsu_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 1024
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: hw/rtl/rsu_div.sv
// ----------------------------------------------------------------------------
// rsu_div
// Restoring divider, one quotient bit per cycle: floor(num * 2^16 / den),
// for num not above den.
// ----------------------------------------------------------------------------
`default_nettype none

module rsu_div #(
	parameter int W = 35
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            start,
	input  wire [W-1:0]                    num,
	input  wire [W-1:0]                    den,
	output logic                           done,
	output logic [rsu_pkg::Q_BITS-1:0]     quot
);

	logic [W:0]                  rem_q;
	logic [W-1:0]                den_q;
	logic [rsu_pkg::QCNT_W-1:0]  cnt_q;
	logic                        busy_q;
	logic                        ge;
	logic [W:0]                  rem_sub;

	assign ge      = rem_q >= {1'b0, den_q};
	assign rem_sub = ge ? (rem_q - {1'b0, den_q}) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rsu_pkg::QCNT_W'(rsu_pkg::Q_BITS - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quot  <= '0;
		end else if (busy_q) begin
			rem_q <= {rem_sub[W-1:0], 1'b0};
			quot  <= {quot[rsu_pkg::Q_BITS-2:0], ge};
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/rank_sum_u_statistic.sv
// ----------------------------------------------------------------------------
// rank_sum_u_statistic
// Mann-Whitney U statistic with tied ranks over a stored sample set.
// ----------------------------------------------------------------------------
// Samples load at one word per cycle into two copies of the sample store.
// The word marked last_sample closes the set; the block then stops taking
// samples, reads every (outer, inner) pair of stored entries from the two
// copies at one pair per cycle, and divides with a one-bit-per-cycle unit.
// For n stored samples the scan covers n*n pairs; if a group is empty the
// scan and the divide are skipped. The result word holds until taken, and
// the next set loads after that.
// ----------------------------------------------------------------------------
`default_nettype none

module rank_sum_u_statistic #(
	parameter int MAX_SAMPLES = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      sample_valid,
	output logic                     sample_ready,
	input  wire rsu_pkg::in_word_t   sample,
	output logic                     result_valid,
	input  wire                      result_ready,
	output rsu_pkg::out_word_t       result
);

	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int IDX_W  = $clog2(MAX_SAMPLES);
	localparam int PAIR_W = 2 * CNT_W;
	localparam int ACC_W  = PAIR_W + 1;
	localparam int ENT_W  = SAMPLE_BITS + 1;

	rsu_pkg::state_t state_q, state_nx;

	logic [CNT_W-1:0] ref_cnt_q, var_cnt_q, stored;
	logic             overflow_q;
	logic [IDX_W-1:0] i_q, j_q, last_idx;
	logic             vld_s1;
	logic [ACC_W-1:0] acc_q, pairs2_q, u2_q;
	logic             empty_q;
	logic             in_acc, out_acc, room, we;
	logic             scan_end;
	logic [ENT_W-1:0] wdata, rd_a, rd_b;
	logic             div_start, div_done;
	logic [rsu_pkg::Q_BITS-1:0] quot;

	assign stored   = CNT_W'(ref_cnt_q + var_cnt_q);
	assign last_idx = IDX_W'(stored - 1'b1);
	assign in_acc   = sample_valid && sample_ready;
	assign out_acc  = result_valid && result_ready;
	assign room     = stored < CNT_W'(MAX_SAMPLES);
	assign we       = in_acc && room;
	assign wdata    = {SAMPLE_BITS'(sample.sample_value), sample.in_variant_group};
	assign scan_end = (i_q == last_idx) && (j_q == last_idx);

	rsu_ram #(.WIDTH(ENT_W), .DEPTH(MAX_SAMPLES)) u_ram_outer (
		.clk   (clk),
		.we    (we),
		.waddr (stored[IDX_W-1:0]),
		.wdata (wdata),
		.raddr (i_q),
		.rdata (rd_a)
	);

	rsu_ram #(.WIDTH(ENT_W), .DEPTH(MAX_SAMPLES)) u_ram_inner (
		.clk   (clk),
		.we    (we),
		.waddr (stored[IDX_W-1:0]),
		.wdata (wdata),
		.raddr (j_q),
		.rdata (rd_b)
	);

	rsu_div #(.W(ACC_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (pairs2_q - acc_q),
		.den    (pairs2_q),
		.done   (div_done),
		.quot   (quot)
	);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			rsu_pkg::ST_LOAD:      if (in_acc && sample.last_sample) state_nx = rsu_pkg::ST_PREP;
			rsu_pkg::ST_PREP:      state_nx = (ref_cnt_q == '0 || var_cnt_q == '0) ?
			                                  rsu_pkg::ST_OUT : rsu_pkg::ST_SCAN;
			rsu_pkg::ST_SCAN:      if (scan_end) state_nx = rsu_pkg::ST_DRAIN;
			rsu_pkg::ST_DRAIN:     state_nx = rsu_pkg::ST_DIV_START;
			rsu_pkg::ST_DIV_START: state_nx = rsu_pkg::ST_DIV_WAIT;
			rsu_pkg::ST_DIV_WAIT:  if (div_done) state_nx = rsu_pkg::ST_OUT;
			rsu_pkg::ST_OUT:       if (out_acc) state_nx = rsu_pkg::ST_LOAD;
			default:               state_nx = rsu_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		sample_ready = state_q == rsu_pkg::ST_LOAD;
		result_valid = state_q == rsu_pkg::ST_OUT;
		div_start    = state_q == rsu_pkg::ST_DIV_START;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rsu_pkg::ST_LOAD;
			ref_cnt_q  <= '0;
			var_cnt_q  <= '0;
			overflow_q <= 1'b0;
			vld_s1     <= 1'b0;
		end else begin
			state_q <= state_nx;
			vld_s1  <= state_q == rsu_pkg::ST_SCAN;
			if (in_acc) begin
				if (!room) begin
					overflow_q <= 1'b1;
				end else if (sample.in_variant_group) begin
					var_cnt_q <= var_cnt_q + 1'b1;
				end else begin
					ref_cnt_q <= ref_cnt_q + 1'b1;
				end
			end
			if (out_acc) begin
				ref_cnt_q  <= '0;
				var_cnt_q  <= '0;
				overflow_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rsu_pkg::ST_PREP: begin
				pairs2_q <= {PAIR_W'(ref_cnt_q) * PAIR_W'(var_cnt_q), 1'b0};
				empty_q  <= (ref_cnt_q == '0) || (var_cnt_q == '0);
				acc_q    <= '0;
				u2_q     <= '0;
				i_q      <= '0;
				j_q      <= '0;
			end
			rsu_pkg::ST_SCAN: begin
				if (j_q == last_idx) begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
			rsu_pkg::ST_DIV_START: u2_q <= pairs2_q - acc_q;
			default: ;
		endcase
		if (vld_s1 && rd_a[0] && !rd_b[0]) begin
			if (rd_a[ENT_W-1:1] > rd_b[ENT_W-1:1]) begin
				acc_q <= acc_q + ACC_W'(2);
			end else if (rd_a[ENT_W-1:1] == rd_b[ENT_W-1:1]) begin
				acc_q <= acc_q + ACC_W'(1);
			end
		end
	end

	always_comb begin
		result.u_var_twice     = rsu_pkg::U_W'(acc_q);
		result.u_ref_twice     = rsu_pkg::U_W'(u2_q);
		result.rho_fraction    = empty_q ? '0 : quot;
		result.empty_group     = empty_q;
		result.dropped_samples = overflow_q;
	end

endmodule

`default_nettype wire

// File: hw/rtl/rsu_checker.sv
// ----------------------------------------------------------------------------
// rsu_checker
// Port-level checks of the rank-sum U statistic block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module rsu_checker (
	input wire                     clk,
	input wire                     arst_n,
	input wire                     sample_valid,
	input wire                     sample_ready,
	input wire rsu_pkg::in_word_t  sample,
	input wire                     result_valid,
	input wire                     result_ready,
	input wire rsu_pkg::out_word_t result
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !sample_ready)
		else $error("sample taken while result pending");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.empty_group |->
			result.u_var_twice == '0 && result.u_ref_twice == '0 &&
			result.rho_fraction == '0)
		else $error("empty group with nonzero result");

	a_parity: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.u_var_twice[0] == result.u_ref_twice[0])
		else $error("twice U1 plus twice U2 is odd");

	a_keep_loading: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready && !sample.last_sample |=> sample_ready)
		else $error("load stopped before last sample");

endmodule

bind rank_sum_u_statistic rsu_checker u_rsu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_ready (sample_ready),
	.sample       (sample),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

`default_nettype wire
